### design/multi_pattern_token_matcher_top_defines.svh
// assertion macros used by the matcher core
`ifndef MULTI_PATTERN_TOKEN_MATCHER_TOP_DEFINES_SVH
`define MULTI_PATTERN_TOKEN_MATCHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MPTM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define MPTM_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define MPTM_ASSERT(lbl, prop, msg)
`define MPTM_NEVER(lbl, expr, msg)
`endif

`endif

### design/mptm_pkg.sv
// types, constants and state codes of the token matcher
package mptm_pkg;

    localparam int NODES        = 256;
    localparam int SYMBOLS      = 256;
    localparam int MAX_DEPTH    = 16;
    localparam int RESULT_LIMIT = 16;

    localparam int NODE_W = $clog2(NODES);
    localparam int SYM_W  = 8;
    localparam int CH_AW  = NODE_W + SYM_W;
    localparam int CNT_W  = NODE_W + 1;
    localparam int LEN_W  = $clog2(MAX_DEPTH + 1);
    localparam int RES_W  = $clog2(RESULT_LIMIT + 1);

    localparam logic [CNT_W-1:0] NODE_LIMIT = CNT_W'(NODES);
    localparam logic [CNT_W-1:0] SYM_LIMIT  = CNT_W'(SYMBOLS);
    localparam logic [LEN_W-1:0] DEPTH_LIM  = LEN_W'(MAX_DEPTH);
    localparam logic [RES_W-1:0] RES_LAST   = RES_W'(RESULT_LIMIT - 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_MATCH  = 1'b1;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_LONG = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  symbol;
        logic        first;
        logic        pattern_end;
        logic [15:0] pattern_id;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [15:0] match_id;
        logic [31:0] match_start;
        logic [31:0] match_end;
        logic [1:0]  status;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [NODE_W-1:0] fail;
        logic [NODE_W-1:0] outl;
        logic              tag_valid;
        logic [15:0]       tag_id;
        logic [LEN_W-1:0]  len;
    } t_node_word;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_INS, S_INS_RD, S_INS_TAG,
        S_RB_INIT, S_RB_POP, S_RB_U, S_RB_S, S_RB_V, S_RB_F0, S_RB_FQ, S_RB_FN,
        S_RB_W, S_RB_WV,
        S_MT_START, S_MT_CQ, S_MT_FN, S_MT_RD, S_MT_N, S_EMIT
    } t_state;

endpackage

### design/multi_pattern_token_matcher_top.sv
// top level of the token matcher: sequencer with memories and output register
// after reset a clearing pass sweeps the child and node tables; no item is taken then
// insert: the next item is taken only after the result of the last one has been passed on
// match: a child lookup per failure hop, then a node read per suffix-only hit or further result
// a match after trie changes first rebuilds links, walking every node and symbol pair
// and each trie edge and failure hop through the single child table read port
module multi_pattern_token_matcher_top
    import mptm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out,
    input  logic      i_out_stall
);

    logic      res_valid, res_stall;
    t_out_item res;

    mptm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_stall (res_stall)
    );

    mptm_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_data  (res),
        .o_stall (res_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out),
        .i_stall (i_out_stall)
    );

endmodule

### design/mptm_out_stage.sv
// two-entry output register between the sequencer and the result channel
module mptm_out_stage
    import mptm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_out_item i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_stall
);

    t_out_item  r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    // handshake on both sides
    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) r_slot[r_wp] <= i_data;
    end

endmodule

### design/mptm_core.sv
// trie, link rebuild and match sequencer around the child and node memories
`include "multi_pattern_token_matcher_top_defines.svh"
module mptm_core
    import mptm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in,
    output logic      o_in_stall,
    output logic      o_res_valid,
    output t_out_item o_res,
    input  logic      i_res_stall
);

    // memories
    logic [NODE_W-1:0] child_mem [2**CH_AW];
    t_node_word        node_mem  [NODES];
    logic [NODE_W-1:0] queue_mem [NODES];

    logic [NODE_W-1:0] ch_q;
    t_node_word        nd_q;
    logic [NODE_W-1:0] q_q;

    logic [CH_AW-1:0]  ch_raddr, ch_waddr;
    logic              ch_we;
    logic [NODE_W-1:0] ch_wdata;
    logic [NODE_W-1:0] nd_raddr, nd_waddr;
    logic              nd_we;
    t_node_word        nd_wdata;
    logic [NODE_W-1:0] q_raddr, q_waddr;
    logic              q_we;
    logic [NODE_W-1:0] q_wdata;

    // control state
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_ncount, n_ncount;
    logic [NODE_W-1:0] r_ins_cur, n_ins_cur;
    logic [1:0]        r_ins_err, n_ins_err;
    logic [NODE_W-1:0] r_match_cur, n_match_cur;
    logic [31:0]       r_pos, n_pos;
    logic              r_links_ok, n_links_ok;
    logic [CH_AW-1:0]  r_clr, n_clr;
    logic [CNT_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_tail, n_tail;
    logic [RES_W-1:0]  r_n, n_n;

    // working registers
    t_in_item          r_item, n_item;
    logic [NODE_W-1:0] r_cur, n_cur;
    logic [NODE_W-1:0] r_node, n_node;
    logic [NODE_W-1:0] r_u, n_u;
    logic [NODE_W-1:0] r_v, n_v;
    logic [NODE_W-1:0] r_f, n_f;
    logic [NODE_W-1:0] r_w, n_w;
    logic [NODE_W-1:0] r_o, n_o;
    logic [CNT_W-1:0]  r_s, n_s;
    logic [31:0]       r_endpos, n_endpos;
    t_out_item         r_res, n_res;

    // shared conditions
    logic [NODE_W-1:0] ins_start;
    logic [1:0]        ins_err0;
    logic              len_full, tbl_full, more_sym, rb_hop, mt_hop, chain_end;
    logic [NODE_W-1:0] mt_start;
    logic [SYM_W-1:0]  sym;

    assign sym       = r_item.symbol;
    assign ins_start = r_item.first ? '0 : r_ins_cur;
    assign ins_err0  = r_item.first ? STAT_OK : r_ins_err;
    assign mt_start  = r_item.first ? '0 : r_match_cur;
    assign len_full  = (nd_q.len >= DEPTH_LIM);
    assign tbl_full  = (r_ncount >= NODE_LIMIT);
    assign more_sym  = (r_s < SYM_LIMIT);
    assign rb_hop    = (r_f != '0) && (ch_q == '0);
    assign mt_hop    = (r_cur != '0) && (ch_q == '0);
    assign chain_end = (nd_q.outl == '0) || (r_n == RES_LAST);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_EMIT);
    assign o_res       = r_res;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:    if (r_clr == '1) n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in.opcode == OP_INSERT) n_state = S_INS;
                    else if (r_links_ok)          n_state = S_MT_START;
                    else                          n_state = S_RB_INIT;
                end
            end
            S_INS:      n_state = (ins_err0 != STAT_OK) ? S_EMIT : S_INS_RD;
            S_INS_RD: begin
                if (!len_full && ch_q != '0 && r_item.pattern_end) n_state = S_INS_TAG;
                else                                             n_state = S_EMIT;
            end
            S_INS_TAG:  n_state = S_EMIT;
            S_RB_INIT:  n_state = S_RB_POP;
            S_RB_POP:   n_state = (r_head < r_tail) ? S_RB_U : S_MT_START;
            S_RB_U:     n_state = S_RB_S;
            S_RB_S:     n_state = more_sym ? S_RB_V : S_RB_POP;
            S_RB_V: begin
                if (ch_q == '0)     n_state = S_RB_S;
                else if (r_u == '0) n_state = S_RB_WV;
                else                n_state = S_RB_F0;
            end
            S_RB_F0:    n_state = S_RB_FQ;
            S_RB_FQ:    n_state = rb_hop ? S_RB_FN : S_RB_W;
            S_RB_FN:    n_state = S_RB_FQ;
            S_RB_W:     n_state = S_RB_WV;
            S_RB_WV:    n_state = S_RB_S;
            S_MT_START: n_state = S_MT_CQ;
            S_MT_CQ:    n_state = mt_hop ? S_MT_FN : S_MT_N;
            S_MT_FN:    n_state = S_MT_CQ;
            S_MT_N: begin
                if (!nd_q.tag_valid && nd_q.outl != '0) n_state = S_MT_RD;
                else                                    n_state = S_EMIT;
            end
            S_MT_RD:    n_state = S_MT_N;
            S_EMIT: begin
                if (!i_res_stall) n_state = r_res.last ? S_IDLE : S_MT_RD;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and memory ports
    always_comb begin
        n_ncount    = r_ncount;
        n_ins_cur   = r_ins_cur;
        n_ins_err   = r_ins_err;
        n_match_cur = r_match_cur;
        n_pos       = r_pos;
        n_links_ok  = r_links_ok;
        n_clr       = r_clr;
        n_head      = r_head;
        n_tail      = r_tail;
        n_n         = r_n;
        n_item      = r_item;
        n_cur       = r_cur;
        n_node      = r_node;
        n_u         = r_u;
        n_v         = r_v;
        n_f         = r_f;
        n_w         = r_w;
        n_o         = r_o;
        n_s         = r_s;
        n_endpos    = r_endpos;
        n_res       = r_res;
        ch_raddr    = {r_cur, sym};
        ch_we       = 1'b0;
        ch_waddr    = {r_cur, sym};
        ch_wdata    = '0;
        nd_raddr    = r_node;
        nd_we       = 1'b0;
        nd_waddr    = r_cur;
        nd_wdata    = nd_q;
        q_raddr     = r_head[NODE_W-1:0];
        q_we        = 1'b0;
        q_waddr     = r_tail[NODE_W-1:0];
        q_wdata     = r_v;
        unique case (r_state)
            S_CLEAR: begin
                ch_we    = 1'b1;
                ch_waddr = r_clr;
                nd_we    = (r_clr[CH_AW-1:NODE_W] == '0);
                nd_waddr = r_clr[NODE_W-1:0];
                nd_wdata = '0;
                n_clr    = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (i_in_valid) n_item = i_in;
            end
            S_INS: begin
                n_cur     = ins_start;
                n_ins_err = ins_err0;
                ch_raddr  = {ins_start, sym};
                nd_raddr  = ins_start;
                n_res     = '{found: 1'b0, match_id: '0, match_start: '0, match_end: '0,
                              status: ins_err0, last: 1'b1};
                if (ins_err0 != STAT_OK) n_ins_cur = ins_start;
            end
            S_INS_RD: begin
                n_res.status = STAT_OK;
                if (len_full) begin
                    n_ins_err    = STAT_LONG;
                    n_ins_cur    = r_cur;
                    n_res.status = STAT_LONG;
                end else if (ch_q == '0) begin
                    if (tbl_full) begin
                        n_ins_err    = STAT_FULL;
                        n_ins_cur    = r_cur;
                        n_res.status = STAT_FULL;
                    end else begin
                        // new node takes the next free number
                        ch_we      = 1'b1;
                        ch_wdata   = r_ncount[NODE_W-1:0];
                        nd_we      = 1'b1;
                        nd_waddr   = r_ncount[NODE_W-1:0];
                        nd_wdata   = '{fail: '0, outl: '0, tag_valid: r_item.pattern_end,
                                       tag_id: r_item.pattern_id, len: nd_q.len + 1'b1};
                        n_ncount   = r_ncount + 1'b1;
                        n_links_ok = 1'b0;
                        n_ins_cur  = r_ncount[NODE_W-1:0];
                    end
                end else begin
                    n_ins_cur = ch_q;
                    n_cur     = ch_q;
                    nd_raddr  = ch_q;
                end
            end
            S_INS_TAG: begin
                // retag an existing node, other fields kept
                nd_we            = 1'b1;
                nd_waddr         = r_cur;
                nd_wdata.tag_valid = 1'b1;
                nd_wdata.tag_id  = r_item.pattern_id;
                n_links_ok       = 1'b0;
            end
            S_RB_INIT: begin
                q_we    = 1'b1;
                q_waddr = '0;
                q_wdata = '0;
                n_head  = '0;
                n_tail  = CNT_W'(1);
            end
            S_RB_POP: begin
                q_raddr = r_head[NODE_W-1:0];
                if (r_head >= r_tail) n_links_ok = 1'b1;
            end
            S_RB_U: begin
                n_u    = q_q;
                n_head = r_head + 1'b1;
                n_s    = '0;
            end
            S_RB_S: begin
                ch_raddr = {r_u, r_s[SYM_W-1:0]};
            end
            S_RB_V: begin
                n_v = ch_q;
                if (ch_q == '0) begin
                    n_s = r_s + 1'b1;
                end else if (r_u == '0) begin
                    n_w      = '0;
                    n_o      = '0;
                    nd_raddr = ch_q;
                end else begin
                    nd_raddr = r_u;
                end
            end
            S_RB_F0, S_RB_FN: begin
                n_f      = nd_q.fail;
                ch_raddr = {nd_q.fail, r_s[SYM_W-1:0]};
            end
            S_RB_FQ: begin
                if (rb_hop) begin
                    nd_raddr = r_f;
                end else begin
                    n_w      = ch_q;
                    nd_raddr = ch_q;
                end
            end
            S_RB_W: begin
                n_o      = nd_q.tag_valid ? r_w : nd_q.outl;
                nd_raddr = r_v;
            end
            S_RB_WV: begin
                nd_we         = 1'b1;
                nd_waddr      = r_v;
                nd_wdata.fail = r_w;
                nd_wdata.outl = r_o;
                if (r_tail < NODE_LIMIT) begin
                    q_we   = 1'b1;
                    n_tail = r_tail + 1'b1;
                end
                n_s = r_s + 1'b1;
            end
            S_MT_START: begin
                n_cur    = mt_start;
                n_pos    = r_item.first ? '0 : r_pos;
                ch_raddr = {mt_start, sym};
            end
            S_MT_CQ: begin
                if (mt_hop) begin
                    nd_raddr = r_cur;
                end else begin
                    n_cur       = ch_q;
                    n_match_cur = ch_q;
                    n_endpos    = r_pos + 32'd1;
                    n_pos       = r_pos + 32'd1;
                    n_n         = '0;
                    n_node      = ch_q;
                    nd_raddr    = ch_q;
                end
            end
            S_MT_FN: begin
                n_cur    = nd_q.fail;
                ch_raddr = {nd_q.fail, sym};
            end
            S_MT_N: begin
                if (nd_q.tag_valid) begin
                    n_res  = '{found: 1'b1, match_id: nd_q.tag_id,
                               match_start: r_endpos - 32'(nd_q.len), match_end: r_endpos,
                               status: STAT_OK, last: chain_end};
                    n_node = nd_q.outl;
                    n_n    = r_n + 1'b1;
                end else if (nd_q.outl != '0) begin
                    n_node = nd_q.outl;
                end else begin
                    n_res = '{found: 1'b0, match_id: '0, match_start: '0, match_end: '0,
                              status: STAT_OK, last: 1'b1};
                end
            end
            S_MT_RD: begin
                nd_raddr = r_node;
            end
            S_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ncount    <= CNT_W'(1);
            r_ins_cur   <= '0;
            r_ins_err   <= STAT_OK;
            r_match_cur <= '0;
            r_pos       <= '0;
            r_links_ok  <= 1'b1;
            r_clr       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_n         <= '0;
        end else begin
            r_state     <= n_state;
            r_ncount    <= n_ncount;
            r_ins_cur   <= n_ins_cur;
            r_ins_err   <= n_ins_err;
            r_match_cur <= n_match_cur;
            r_pos       <= n_pos;
            r_links_ok  <= n_links_ok;
            r_clr       <= n_clr;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_n         <= n_n;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_cur    <= n_cur;
        r_node   <= n_node;
        r_u      <= n_u;
        r_v      <= n_v;
        r_f      <= n_f;
        r_w      <= n_w;
        r_o      <= n_o;
        r_s      <= n_s;
        r_endpos <= n_endpos;
        r_res    <= n_res;
    end

    // child table memory
    always_ff @(posedge i_clk) begin
        if (ch_we) child_mem[ch_waddr] <= ch_wdata;
        ch_q <= child_mem[ch_raddr];
    end

    // node memory: links, tag and depth
    always_ff @(posedge i_clk) begin
        if (nd_we) node_mem[nd_waddr] <= nd_wdata;
        nd_q <= node_mem[nd_raddr];
    end

    // breadth-first walk queue
    always_ff @(posedge i_clk) begin
        if (q_we) queue_mem[q_waddr] <= q_wdata;
        q_q <= queue_mem[q_raddr];
    end

    `MPTM_ASSERT(a_ncount_max, r_ncount <= NODE_LIMIT, "node count above table size")
    `MPTM_ASSERT(a_cursor_live, {1'b0, r_match_cur} < r_ncount, "match cursor on unused node")
    `MPTM_NEVER(a_queue_order, r_head > r_tail, "walk queue read past its tail")
    `MPTM_ASSERT(a_found_ok, (o_res_valid && o_res.found) |-> (o_res.status == STAT_OK),
                 "match result with error status")

endmodule

### bench/multi_pattern_token_matcher_checker.sv
// checker of the token matcher: watches both channels, predicts results and compares them
module multi_pattern_token_matcher_checker
    import mptm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in,
    input  logic      i_in_stall,
    input  logic      i_out_valid,
    input  t_out_item i_out,
    input  logic      i_out_stall,
    output int        o_errors,
    output int        o_pending
);

    localparam int EXP_DEPTH = 4096;

    // shadow copy of the automaton
    logic [7:0]  trie_child [0:65535];
    logic [7:0]  fail_to    [0:255];
    logic [7:0]  dict_link  [0:255];
    logic [16:0] node_id_tag[0:255];
    logic [4:0]  node_depth [0:255];
    logic [7:0]  bfs_order  [0:255];
    int          node_total;
    logic [7:0]  insert_at;
    logic [7:0]  text_state;
    logic [31:0] text_pos;
    logic        links_stale;
    logic [1:0]  pattern_err;

    // ring of expected results
    t_out_item   expected_mem [0:EXP_DEPTH-1];
    int          exp_wr;
    int          exp_rd;
    int          err_count;

    assign o_pending = exp_wr - exp_rd;
    assign o_errors  = err_count;

    // shadow state after reset
    task automatic clear_shadow();
        for (int i = 0; i < 65536; i++) trie_child[i] = '0;
        for (int i = 0; i < 256; i++) begin
            fail_to[i]     = '0;
            dict_link[i]   = '0;
            node_id_tag[i] = '0;
            node_depth[i]  = '0;
        end
        node_total  = 1;
        insert_at   = '0;
        text_state  = '0;
        text_pos    = '0;
        links_stale = 1'b0;
        pattern_err = STAT_OK;
        exp_wr      = 0;
        exp_rd      = 0;
    endtask

    task automatic add_expected(input t_out_item r);
        expected_mem[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endtask

    // expected results of one accepted item
    task automatic advance_automaton(input t_in_item it);
        logic [7:0]  cur, c, node, u, v, w, f;
        logic [31:0] endpos;
        int          head, tail, n;
        t_out_item   r;
        if (it.opcode == OP_INSERT) begin
            cur = it.first ? 8'd0 : insert_at;
            if (it.first) pattern_err = STAT_OK;
            if (pattern_err == STAT_OK) begin
                if (node_depth[cur] >= 5'(MAX_DEPTH)) begin
                    pattern_err = STAT_LONG;
                end else begin
                    c = trie_child[{cur, it.symbol}];
                    if (c == 0) begin
                        if (node_total >= NODES) begin
                            pattern_err = STAT_FULL;
                        end else begin
                            c = 8'(node_total);
                            node_total++;
                            trie_child[{cur, it.symbol}] = c;
                            node_depth[c]  = node_depth[cur] + 5'd1;
                            node_id_tag[c] = '0;
                            links_stale    = 1'b1;
                        end
                    end
                    if (pattern_err == STAT_OK) begin
                        cur = c;
                        if (it.pattern_end) begin
                            node_id_tag[cur] = {1'b1, it.pattern_id};
                            links_stale = 1'b1;
                        end
                    end
                end
            end
            insert_at = cur;
            r = '0;
            r.status = pattern_err;
            r.last = 1'b1;
            add_expected(r);
        end else begin
            // breadth-first rebuild of failure and dictionary links
            if (links_stale) begin
                head = 0;
                tail = 1;
                bfs_order[0] = '0;
                fail_to[0]   = '0;
                dict_link[0] = '0;
                while (head < tail && head < NODES) begin
                    u = bfs_order[head];
                    head++;
                    for (int s = 0; s < SYMBOLS; s++) begin
                        v = trie_child[{u, 8'(s)}];
                        if (v != 0) begin
                            w = '0;
                            if (u != 0) begin
                                f = fail_to[u];
                                while (f != 0 && trie_child[{f, 8'(s)}] == 0) f = fail_to[f];
                                w = trie_child[{f, 8'(s)}];
                            end
                            fail_to[v]   = w;
                            dict_link[v] = node_id_tag[w][16] ? w : dict_link[w];
                            if (tail < NODES) begin
                                bfs_order[tail] = v;
                                tail++;
                            end
                        end
                    end
                end
                links_stale = 1'b0;
            end
            if (it.first) begin
                text_state = '0;
                text_pos   = '0;
            end
            cur = text_state;
            while (cur != 0 && trie_child[{cur, it.symbol}] == 0) cur = fail_to[cur];
            cur = trie_child[{cur, it.symbol}];
            text_state = cur;
            endpos   = text_pos + 32'd1;
            text_pos = endpos;
            node = node_id_tag[cur][16] ? cur : dict_link[cur];
            n = 0;
            while (node != 0 && n < RESULT_LIMIT) begin
                r = '0;
                r.found       = 1'b1;
                r.match_id    = node_id_tag[node][15:0];
                r.match_start = endpos - 32'(node_depth[node]);
                r.match_end   = endpos;
                add_expected(r);
                n++;
                node = dict_link[node];
            end
            if (n == 0) add_expected('0);
            expected_mem[(exp_wr - 1) % EXP_DEPTH].last = 1'b1;
        end
    endtask

    // predict on input transfer, compare on output transfer
    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            clear_shadow();
        end else begin
            if (i_in_valid && !i_in_stall) advance_automaton(i_in);
            if (i_out_valid && !i_out_stall) begin
                if (exp_wr == exp_rd) begin
                    $error("result transfer with nothing expected: %h", i_out);
                    err_count++;
                end else begin
                    e = expected_mem[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (i_out.found !== e.found) begin
                        $error("found: expected %0d actual %0d", e.found, i_out.found);
                        err_count++;
                    end
                    if (i_out.match_id !== e.match_id) begin
                        $error("match_id: expected %0d actual %0d", e.match_id, i_out.match_id);
                        err_count++;
                    end
                    if (i_out.match_start !== e.match_start) begin
                        $error("match_start: expected %0d actual %0d",
                               e.match_start, i_out.match_start);
                        err_count++;
                    end
                    if (i_out.match_end !== e.match_end) begin
                        $error("match_end: expected %0d actual %0d",
                               e.match_end, i_out.match_end);
                        err_count++;
                    end
                    if (i_out.status !== e.status) begin
                        $error("status: expected %0d actual %0d", e.status, i_out.status);
                        err_count++;
                    end
                    if (i_out.last !== e.last) begin
                        $error("last: expected %0d actual %0d", e.last, i_out.last);
                        err_count++;
                    end
                end
            end
        end
    end

endmodule

### bench/multi_pattern_token_matcher_top_tb.sv
// testbench top of the token matcher: clock, reset, stimulus, stalls and verdict
module multi_pattern_token_matcher_top_tb;
    import mptm_pkg::*;

    localparam int QUIET_LIMIT = 400000;
    localparam int HOLD_CYCLES = 500;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      in_valid;
    t_in_item  in_item;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    logic      out_stall = 1'b1;
    int        errors;
    int        pending;
    int        sent;
    int        quiet = 0;
    bit        hold_done = 1'b0;
    int        hold_left = 0;

    multi_pattern_token_matcher_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in        (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out       (out_item),
        .i_out_stall (out_stall)
    );

    multi_pattern_token_matcher_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in        (in_item),
        .i_in_stall  (in_stall),
        .i_out_valid (out_valid),
        .i_out       (out_item),
        .i_out_stall (out_stall),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // idle percentages by phase: sender busy early, receiver busy next, then both always busy
    function automatic int send_idle_pct();
        return (sent < 135) ? 30 : (sent < 270) ? 84 : 0;
    endfunction

    function automatic int recv_idle_pct();
        return (sent < 135) ? 84 : (sent < 270) ? 30 : 0;
    endfunction

    // receiver stalls, with one long hold-off to fill the block
    always @(negedge i_clk) begin
        if (!hold_done && sent >= 60) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct());
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
        else quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("** multi_pattern_token_matcher_top: FAILED **");
            $finish;
        end
    end

    // one input transfer, entered and left at a falling edge
    task automatic send_item(input logic op, input logic [7:0] sym, input logic fst,
                             input logic pend, input logic [15:0] id);
        while ($urandom_range(99) < send_idle_pct()) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{opcode: op, symbol: sym, first: fst, pattern_end: pend, pattern_id: id};
        do @(posedge i_clk); while (in_stall);
        sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_symbol();
        return ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    endfunction

    initial begin
        int len;
        int span;
        logic [15:0] id;
        in_valid = 1'b0;
        in_item  = '0;
        sent     = 0;
        i_rst_n  = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // chain of 16 tagged prefixes, then past the depth limit
        for (int i = 0; i < 18; i++)
            send_item(OP_INSERT, 8'hFF, i == 0, 1'b1, (i == 0) ? 16'hFFFF : 16'(i));
        // re-tag a node with id zero, and a lone zero-symbol pattern
        send_item(OP_INSERT, 8'hFF, 1'b1, 1'b1, 16'h0000);
        send_item(OP_INSERT, 8'h00, 1'b1, 1'b1, 16'h8001);
        // text that reports the full chain, then a hit on the zero-symbol pattern and a miss in a new text
        for (int i = 0; i < 17; i++) send_item(OP_MATCH, 8'hFF, i == 0, 1'b0, 16'h0);
        send_item(OP_MATCH, 8'h00, 1'b0, 1'b0, 16'hFFFF);
        send_item(OP_MATCH, 8'h55, 1'b1, 1'b1, 16'h1234);

        // random blocks: a few patterns, then a stretch of text
        for (int b = 0; b < 8; b++) begin
            for (int p = 0; p < 2; p++) begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                    send_item(OP_INSERT, pick_symbol(), (k == 0) && ($urandom_range(9) != 0),
                              (k == len - 1) || ($urandom_range(3) == 0), 16'($urandom));
            end
            span = $urandom_range(7, 12);
            for (int k = 0; k < span; k++) begin
                if ($urandom_range(19) == 0) begin
                    // noise: a fully random match item
                    send_item(OP_MATCH, 8'($urandom), 1'($urandom), 1'($urandom),
                              16'($urandom));
                end else begin
                    send_item(OP_MATCH, pick_symbol(), $urandom_range(24) == 0,
                              1'($urandom), 16'($urandom));
                end
            end
        end

        // fill the node table, keep going while full, then recover with a new pattern
        for (int p = 0; p < 15; p++) begin
            id = 16'($urandom);
            for (int k = 0; k < 16; k++)
                send_item(OP_INSERT, 8'($urandom), k == 0, k == 15, id);
        end
        send_item(OP_INSERT, 8'h7E, 1'b0, 1'b1, 16'hABCD);
        send_item(OP_INSERT, 8'hFF, 1'b1, 1'b1, 16'h4321);
        for (int k = 0; k < 6; k++) send_item(OP_MATCH, 8'hFF, k == 0, 1'b0, 16'h0);

        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("** multi_pattern_token_matcher_top: PASSED **");
        end else begin
            $display("** multi_pattern_token_matcher_top: FAILED **");
        end
        $finish;
    end

endmodule
